>>> src/fwbrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwbrl_pkg: shared types and constants
// Field widths, window constants and the sequencer state type of the
// fixed-window byte rate limiter.
// ----------------------------------------------------------------------------
package fwbrl_pkg;

    localparam int BYTE_W  = 16;
    localparam int LIMIT_W = 16;
    localparam int WORD_W  = 32;
    localparam int AGE_W   = 11;
    localparam int CNT_W   = 5;
    localparam int KB_SH   = 10;

    localparam logic [AGE_W-1:0] WINDOW_MS = AGE_W'(1000);
    localparam logic [AGE_W-1:0] AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(WORD_W - 1);

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } fwbrl_state_t;

endpackage
`default_nettype wire

>>> src/fwbrl_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwbrl_req_if: request channel
// Valid/ready channel carrying ticks and byte-count reports.
// ----------------------------------------------------------------------------
interface fwbrl_req_if;
    import fwbrl_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] byte_count;

    modport source (output valid, output req_type, output byte_count, input ready);
    modport sink   (input valid, input req_type, input byte_count, output ready);
endinterface
`default_nettype wire

>>> src/fwbrl_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwbrl_rsp_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface fwbrl_rsp_if;
    import fwbrl_pkg::*;

    logic              valid;
    logic              ready;
    logic              pause_needed;
    logic [WORD_W-1:0] pause_ms;
    logic [WORD_W-1:0] window_total;

    modport source (output valid, output pause_needed, output pause_ms,
                    output window_total, input ready);
    modport sink   (input valid, input pause_needed, input pause_ms,
                    input window_total, output ready);
endinterface
`default_nettype wire

>>> src/fixed_window_byte_rate_limiter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_window_byte_rate_limiter_unit: fixed-window byte rate limiter
// Counts reported bytes per window and issues a pause when the window
// total goes over limit_kb_per_s * 1024 bytes.
//
// Usage:
//   req carries ticks (req_type 0) and byte reports (req_type 1); rsp
//   returns one result per request transfer. cfg_we/cfg_wdata write the
//   limit in KB/s; write only while idle. Zero disables limiting.
//   Ticks and reports that stay under the limit produce their result in the
//   cycle after the transfer. A report that goes over the limit runs a
//   radix-2 restoring divide of the excess by the limit on one shared
//   subtractor in ST_DIV, then the final saturating add in ST_FIN, before
//   its result is registered.
//   req.ready is low while the divide runs and while a result is held
//   that the receiver has not taken.
//   A stalled receiver holds the result register; nothing is dropped.
//   Reset clears the limit, window age, window total and pause countdown.
// ----------------------------------------------------------------------------
module fixed_window_byte_rate_limiter_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire [fwbrl_pkg::LIMIT_W-1:0]  cfg_wdata,
    fwbrl_req_if.sink                     req,
    fwbrl_rsp_if.source                   rsp
);
    import fwbrl_pkg::*;

    fwbrl_state_t        state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [AGE_W-1:0]    age_reg, age_next;
    logic [WORD_W-1:0]   bytes_reg, bytes_next;
    logic [WORD_W-1:0]   pause_left_reg, pause_left_next;
    logic [WORD_W-1:0]   quo_reg, quo_next;
    logic [LIMIT_W-1:0]  rem_reg, rem_next;
    logic [AGE_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                need_reg, need_next;
    logic [WORD_W-1:0]   pause_ms_reg, pause_ms_next;
    logic [WORD_W-1:0]   total_reg, total_next;

    logic                accept;
    logic [WORD_W:0]     sum;
    logic [WORD_W-1:0]   total_sat;
    logic [WORD_W-1:0]   cap;
    logic [WORD_W-1:0]   bytes_ext;
    logic                over;
    logic [LIMIT_W:0]    shifted;
    logic [LIMIT_W:0]    diff;
    logic                qbit;
    logic [WORD_W:0]     psum;
    logic [WORD_W-1:0]   pause_sat;

    assign req.ready        = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.pause_needed = need_reg;
    assign rsp.pause_ms     = pause_ms_reg;
    assign rsp.window_total = total_reg;

    assign bytes_ext = {{(WORD_W-BYTE_W){1'b0}}, req.byte_count};
    assign sum       = {1'b0, bytes_reg} + {1'b0, bytes_ext};
    assign total_sat = sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
    assign cap       = {{(WORD_W-LIMIT_W-KB_SH){1'b0}}, limit_reg, {KB_SH{1'b0}}};
    assign over      = (limit_reg != '0) && (total_sat > cap);

    // one restoring divide step
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, limit_reg};
    assign qbit    = (shifted >= {1'b0, limit_reg});

    assign psum      = {1'b0, quo_reg} + {{(WORD_W+1-AGE_W){1'b0}}, base_reg};
    assign pause_sat = psum[WORD_W] ? {WORD_W{1'b1}} : psum[WORD_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        age_next        = age_reg;
        bytes_next      = bytes_reg;
        pause_left_next = pause_left_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        need_next       = need_reg;
        pause_ms_next   = pause_ms_reg;
        total_next      = total_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    need_next     = 1'b0;
                    pause_ms_next = '0;
                    if (req.req_type == REQ_TICK)
                    begin
                        out_valid_next = 1'b1;
                        total_next     = bytes_reg;
                        if (pause_left_reg != '0)
                        begin
                            pause_left_next = pause_left_reg - WORD_W'(1);
                            age_next        = '0;
                        end
                        else if (age_reg != AGE_MAX)
                        begin
                            age_next = age_reg + AGE_W'(1);
                        end
                    end
                    else if (age_reg > WINDOW_MS)
                    begin
                        out_valid_next = 1'b1;
                        age_next       = '0;
                        bytes_next     = bytes_ext;
                        total_next     = bytes_ext;
                    end
                    else if (over)
                    begin
                        base_next  = WINDOW_MS - age_reg;
                        quo_next   = total_sat - cap;
                        rem_next   = '0;
                        cnt_next   = '0;
                        age_next   = '0;
                        bytes_next = bytes_ext;
                        total_next = bytes_ext;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        bytes_next     = total_sat;
                        total_next     = total_sat;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = qbit ? diff[LIMIT_W-1:0] : shifted[LIMIT_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], qbit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                pause_left_next = pause_sat;
                pause_ms_next   = pause_sat;
                need_next       = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= '0;
            age_reg        <= '0;
            bytes_reg      <= '0;
            pause_left_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            age_reg        <= age_next;
            bytes_reg      <= bytes_next;
            pause_left_reg <= pause_left_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        base_reg     <= base_next;
        need_reg     <= need_next;
        pause_ms_reg <= pause_ms_next;
        total_reg    <= total_next;
    end

`ifndef NO_ASSERTIONS
    a_div_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("result pending while divide runs");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == REQ_TICK)) |=> (out_valid_reg && !need_reg))
        else $error("tick did not produce a plain result");

    a_pause_age: assert property (@(posedge clk) disable iff (!rst_n)
        (pause_left_reg != '0) |-> (age_reg == '0))
        else $error("window aging during pause");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < limit_reg))
        else $error("divide remainder out of range");
`endif

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for fixed_window_byte_rate_limiter_unit
// Drives ticks and byte reports over the request channel under several
// limit settings and checks every result against a built-in model of the
// window age, window total and pause countdown, or a directed row's literal.
// Directed table first, then random traffic, then a short run without idling.
// ----------------------------------------------------------------------------
module tb;
    import fwbrl_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 85;
    localparam int N_DIR        = 19;

    typedef struct packed {
        logic              pause_needed;
        logic [WORD_W-1:0] pause_ms;
        logic [WORD_W-1:0] window_total;
    } rate_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_SETLIMIT
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               rt;
        logic [BYTE_W-1:0]  val;
        logic               lit;
        rate_result_t       want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;

    fwbrl_req_if req_ch ();
    fwbrl_rsp_if rsp_ch ();

    fixed_window_byte_rate_limiter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // limiter model state
    logic [LIMIT_W-1:0]  lim_kb;
    logic [AGE_W-1:0]    win_age;
    logic [WORD_W-1:0]   win_bytes;
    logic [WORD_W-1:0]   pause_left;

    rate_result_t        pending_results [$];
    rate_result_t        want_now;
    dir_row_t            dir_rows [N_DIR];

    bit tx_idle_on;
    bit rx_idle_on;
    int err_count;
    int cycle_count;
    int results_seen;
    int xfer_count;
    int pause_count;
    int new_window_count;
    int sat_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic rate_result_t step_limiter(input logic rt, input logic [BYTE_W-1:0] bc);
        rate_result_t      res;
        logic [WORD_W:0]   sum;
        logic [WORD_W-1:0] cap;
        logic [WORD_W-1:0] excess;
        logic [WORD_W:0]   wait_ms;
        res = '0;
        if (rt == REQ_TICK)
        begin
            if (pause_left != 0)
            begin
                pause_left = pause_left - 1;
                win_age = '0;
            end
            else if (win_age != AGE_MAX)
            begin
                win_age = win_age + AGE_W'(1);
            end
        end
        else if (win_age > WINDOW_MS)
        begin
            win_age = '0;
            win_bytes = {16'b0, bc};
            new_window_count++;
        end
        else
        begin
            sum = {1'b0, win_bytes} + {17'b0, bc};
            if (sum[WORD_W])
                sat_count++;
            win_bytes = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
            cap = {6'b0, lim_kb, 10'b0};
            if (lim_kb != 0 && win_bytes > cap)
            begin
                excess = win_bytes - cap;
                wait_ms = {1'b0, {21'b0, WINDOW_MS} - {21'b0, win_age}}
                          + {1'b0, excess / {16'b0, lim_kb}};
                res.pause_needed = 1'b1;
                res.pause_ms = wait_ms[WORD_W] ? '1 : wait_ms[WORD_W-1:0];
                pause_left = res.pause_ms;
                win_age = '0;
                win_bytes = {16'b0, bc};
                pause_count++;
            end
        end
        res.window_total = win_bytes;
        return res;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_bytes();
        logic [WORD_W-1:0] cap;
        logic [WORD_W-1:0] hi;
        int                r;
        cap = {6'b0, lim_kb, 10'b0};
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r <= 4)
            return BYTE_W'($urandom);
        // land right on or just past the cap
        if (r == 5 && lim_kb != 0 && win_bytes < cap && cap - win_bytes <= 32'hFFFE)
            return BYTE_W'(cap - win_bytes) + BYTE_W'($urandom_range(0, 1));
        if (lim_kb == 0)
            return BYTE_W'($urandom_range(0, 4095));
        hi = (cap / 3 > 32'hFFFF) ? 32'hFFFF : cap / 3;
        return BYTE_W'($urandom_range(0, hi));
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        err_count++;
        $display("mismatch at result %0d: %s got 0x%08h want 0x%08h", results_seen, what,
                 got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transfer, window_total", rsp_ch.window_total, '0);
            end
            else
            begin
                want_now = pending_results.pop_front();
                if (rsp_ch.pause_needed !== want_now.pause_needed)
                    report_mismatch("pause_needed", {31'b0, rsp_ch.pause_needed},
                                    {31'b0, want_now.pause_needed});
                if (rsp_ch.pause_ms !== want_now.pause_ms)
                    report_mismatch("pause_ms", rsp_ch.pause_ms, want_now.pause_ms);
                if (rsp_ch.window_total !== want_now.window_total)
                    report_mismatch("window_total", rsp_ch.window_total,
                                    want_now.window_total);
            end
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_req(input logic rt, input logic [BYTE_W-1:0] bc, input logic use_lit,
                            input rate_result_t lit);
        rate_result_t calc;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rt;
        req_ch.byte_count <= bc;
        do
            @(posedge clk);
        while (!req_ch.ready);
        xfer_count++;
        calc = step_limiter(rt, bc);
        pending_results.push_back(use_lit ? lit : calc);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_kb = v;
    endtask

    task automatic run_phase(input int n_items, input bit idle_on);
        int sent;
        int r;
        tx_idle_on = idle_on;
        rx_idle_on = idle_on;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_req(REQ_TICK, BYTE_W'($urandom), 1'b0, '0);
            else
                send_req(REQ_REPORT, pick_bytes(), 1'b0, '0);
            sent++;
            if (sent == n_items / 2)
            begin
                tx_idle_on = !idle_on;
                rx_idle_on = !idle_on;
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_TICK;
        req_ch.byte_count <= '0;
        lim_kb     = '0;
        win_age    = '0;
        win_bytes  = '0;
        pause_left = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        dir_rows = '{
            '{ROW_ITEM,     REQ_TICK,   16'h0000, 1'b1, '{1'b0, 32'd0,    32'h0}},
            '{ROW_ITEM,     REQ_REPORT, 16'h0000, 1'b1, '{1'b0, 32'd0,    32'h0}},
            '{ROW_ITEM,     REQ_REPORT, 16'hFFFF, 1'b1, '{1'b0, 32'd0,    32'hFFFF}},
            '{ROW_ITEM,     REQ_REPORT, 16'hFFFF, 1'b1, '{1'b0, 32'd0,    32'h1FFFE}},
            '{ROW_SETLIMIT, REQ_TICK,   16'hFFFF, 1'b0, '0},
            '{ROW_ITEM,     REQ_REPORT, 16'h8000, 1'b1, '{1'b0, 32'd0,    32'h27FFE}},
            '{ROW_SETLIMIT, REQ_TICK,   16'h0001, 1'b0, '0},
            '{ROW_ITEM,     REQ_REPORT, 16'h0001, 1'b0, '0},
            '{ROW_ITEM,     REQ_REPORT, 16'h0400, 1'b1, '{1'b1, 32'd1001, 32'h400}},
            '{ROW_ITEM,     REQ_TICK,   16'h0000, 1'b1, '{1'b0, 32'd0,    32'h400}},
            '{ROW_ITEM,     REQ_REPORT, 16'h03FF, 1'b1, '{1'b1, 32'd2023, 32'h3FF}},
            '{ROW_SETLIMIT, REQ_TICK,   16'h0002, 1'b0, '0},
            '{ROW_ITEM,     REQ_REPORT, 16'h0401, 1'b1, '{1'b0, 32'd0,    32'h800}},
            '{ROW_ITEM,     REQ_REPORT, 16'h0001, 1'b1, '{1'b1, 32'd1000, 32'h1}},
            '{ROW_SETLIMIT, REQ_TICK,   16'h0000, 1'b0, '0},
            '{ROW_ITEM,     REQ_TICK,   16'h0000, 1'b0, '0},
            '{ROW_ITEM,     REQ_TICK,   16'hFFFF, 1'b0, '0},
            '{ROW_ITEM,     REQ_REPORT, 16'hFFFF, 1'b0, '0},
            '{ROW_ITEM,     REQ_REPORT, 16'h5A5A, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].kind == ROW_SETLIMIT)
                write_limit(dir_rows[i].val);
            else
                send_req(dir_rows[i].rt, dir_rows[i].val, dir_rows[i].lit, dir_rows[i].want);
        end

        run_phase(PHASE_ITEMS, 1'b1);
        write_limit(16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0);
        write_limit(16'h0001);
        run_phase(PHASE_ITEMS, 1'b1);
        write_limit(LIMIT_W'($urandom_range(2, 64)));
        run_phase(PHASE_ITEMS, 1'b0);
        write_limit(LIMIT_W'($urandom_range(65, 3000)));
        run_phase(PHASE_ITEMS, 1'b1);

        // closing stretch at full rate
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_limit(16'h0001);
        send_req(REQ_REPORT, 16'h1234, 1'b0, '0);
        repeat (5) send_req(REQ_TICK, BYTE_W'($urandom), 1'b0, '0);
        send_req(REQ_REPORT, 16'hFFFF, 1'b0, '0);
        send_req(REQ_REPORT, 16'h0000, 1'b0, '0);

        wait_drained();
        $display("%0d transfers, %0d results, %0d pauses, %0d reopened windows",
                 xfer_count, results_seen, pause_count, new_window_count);
        $display("%0d saturated totals, %0d mismatches", sat_count, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/fwbrl_pkg.sv
src/fwbrl_req_if.sv
src/fwbrl_rsp_if.sv
src/fixed_window_byte_rate_limiter_unit.sv
test/tb.sv
